// ----- design/ked_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ked_pkg - shared types and constants of the key event detector
// Register widths, reset values, event codes and the per-lane structures used
// by the key lanes, the merging stage and the top level.
// -----------------------------------------------------------------------------
package ked_pkg;

   localparam int FILTER_W = 5;
   localparam int LONG_W   = 16;
   localparam int REPEAT_W = 16;
   localparam int WINDOW_W = 8;
   localparam int DEB_W    = FILTER_W + 1;
   localparam int CODE_W   = 2;

   localparam int APB_ADDR_W = 4;
   localparam int APB_DATA_W = 32;

   localparam logic [FILTER_W-1:0] FILTER_RST = 5'd5;
   localparam logic [LONG_W-1:0]   LONG_RST   = 16'd100;
   localparam logic [REPEAT_W-1:0] REPEAT_RST = 16'd100;
   localparam logic [WINDOW_W-1:0] WINDOW_RST = 8'd30;
   localparam logic [DEB_W-1:0]    DEB_RST    = 6'd2;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef enum logic [CODE_W-1:0] {
      EV_DOWN   = 2'd0,
      EV_UP     = 2'd1,
      EV_LONG   = 2'd2,
      EV_DOUBLE = 2'd3
   } ev_code_type;

   typedef enum logic [1:0] {
      REG_FILTER = 2'd0,
      REG_LONG   = 2'd1,
      REG_REPEAT = 2'd2,
      REG_WINDOW = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [FILTER_W-1:0] filter_time;
      logic [LONG_W-1:0]   long_time;
      logic [REPEAT_W-1:0] repeat_period;
      logic [WINDOW_W-1:0] double_window;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      ev_code_type code;
   } lane_ev_type;

endpackage

// ----- design/ked_if.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ked_if - request and response channels of the key event detector
// Valid/ready channels; a transaction moves when valid and ready are both high.
// -----------------------------------------------------------------------------
interface ked_req_if #(parameter int NUM_KEYS = 3);
   logic                valid;
   logic                ready;
   logic                kind;
   logic [NUM_KEYS-1:0] key_levels;

   modport source (output valid, output kind, output key_levels, input ready);
   modport sink   (input valid, input kind, input key_levels, output ready);
endinterface

interface ked_rsp_if #(parameter int KEY_W = 2);
   logic                        valid;
   logic                        ready;
   logic                        event_valid;
   logic [KEY_W-1:0]            key_index;
   logic [ked_pkg::CODE_W-1:0]  event_code;
   logic                        events_lost;

   modport source (output valid, output event_valid, output key_index,
                   output event_code, output events_lost, input ready);
   modport sink   (input valid, input event_valid, input key_index,
                   input event_code, input events_lost, output ready);
endinterface

// ----- design/key_event_detector_core.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// key_event_detector_core - multi-key event detector with event queue
// Per-key debounce, long press with auto-repeat and double-click detection in
// parallel lanes, merged in key order into an event queue that is read one
// event per read transaction.
//
//   Channel  Direction  Handshake                 Carries
//   req_ch   in         valid/ready               kind, key_levels
//   rsp_ch   out        valid/ready               event_valid, key_index,
//                                                 event_code, events_lost
//   APB      in         psel/penable, pready = 1  filter_time, long_time,
//                                                 repeat_period, double_window
//
// A scan tick updates every key lane at once; the events it raises are then
// written into the queue one per cycle, lowest key first, and the merging
// stage holds further requests off until the last of them is written. A read
// transaction passes through the queue read stage and the output register
// before its response appears; reads may follow each other back to back while
// responses are taken. A stalled response holds in the output register while
// one further read proceeds into the queue read stage. Reset is synchronous
// and needs no clearing pass: the queue is tracked by its fill count.
// -----------------------------------------------------------------------------
module key_event_detector_core #(
   parameter int NUM_KEYS   = 3,
   parameter int FIFO_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   ked_req_if.sink                        req_ch,
   ked_rsp_if.source                      rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ked_pkg::APB_ADDR_W-1:0] paddr,
   input  logic [ked_pkg::APB_DATA_W-1:0] pwdata,
   output logic [ked_pkg::APB_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int ENT_W = KEY_W + ked_pkg::CODE_W;

   // ---------------------------------------------------------------------
   // Configuration registers. Only the upper address bits select a register,
   // so every address maps onto one of the four.
   // ---------------------------------------------------------------------
   ked_pkg::cfg_type     cfg_ff, cfg_in;
   ked_pkg::reg_idx_type reg_sel;
   logic                 csr_write;

   assign pready    = 1'b1;
   assign reg_sel   = ked_pkg::reg_idx_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_sel)
            ked_pkg::REG_FILTER: cfg_in.filter_time   = pwdata[ked_pkg::FILTER_W-1:0];
            ked_pkg::REG_LONG:   cfg_in.long_time     = pwdata[ked_pkg::LONG_W-1:0];
            ked_pkg::REG_REPEAT: cfg_in.repeat_period = pwdata[ked_pkg::REPEAT_W-1:0];
            ked_pkg::REG_WINDOW: cfg_in.double_window = pwdata[ked_pkg::WINDOW_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         ked_pkg::REG_FILTER: prdata = ked_pkg::APB_DATA_W'(cfg_ff.filter_time);
         ked_pkg::REG_LONG:   prdata = ked_pkg::APB_DATA_W'(cfg_ff.long_time);
         ked_pkg::REG_REPEAT: prdata = ked_pkg::APB_DATA_W'(cfg_ff.repeat_period);
         ked_pkg::REG_WINDOW: prdata = ked_pkg::APB_DATA_W'(cfg_ff.double_window);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{filter_time:   ked_pkg::FILTER_RST,
                     long_time:     ked_pkg::LONG_RST,
                     repeat_period: ked_pkg::REPEAT_RST,
                     double_window: ked_pkg::WINDOW_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------
   // Request acceptance. The block stalls requests while tick events are
   // still being written into the queue, so a later read always sees them,
   // and while the read stage and a stalled output register are both full.
   // ---------------------------------------------------------------------
   logic req_accept, tick, pop;
   logic merge_busy;
   logic s1_valid_ff, s1_valid_in, s1_move;
   logic out_valid_ff, out_valid_in;

   assign s1_move      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !merge_busy && !(s1_valid_ff && out_valid_ff && !rsp_ch.ready);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign tick         = req_accept && (req_ch.kind == ked_pkg::KIND_TICK);
   assign pop          = req_accept && (req_ch.kind == ked_pkg::KIND_READ);

   // ---------------------------------------------------------------------
   // Key lanes, one per key, all updated on the same tick.
   // ---------------------------------------------------------------------
   ked_pkg::lane_ev_type lane_ev [NUM_KEYS];

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      ked_lane u_lane (
         .clock (clock),
         .reset (reset),
         .tick  (tick),
         .down  (req_ch.key_levels[k]),
         .cfg   (cfg_ff),
         .ev    (lane_ev[k])
      );
   end

   // ---------------------------------------------------------------------
   // Merging stage and event queue.
   // ---------------------------------------------------------------------
   logic                       push_valid;
   logic [KEY_W-1:0]           push_key;
   logic [ked_pkg::CODE_W-1:0] push_code;
   logic [ENT_W-1:0]           rd_data;
   logic                       rd_empty, rd_lost;

   ked_merge #(
      .NUM_KEYS (NUM_KEYS),
      .KEY_W    (KEY_W)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .lane_ev    (lane_ev),
      .busy       (merge_busy),
      .push_valid (push_valid),
      .push_key   (push_key),
      .push_code  (push_code)
   );

   ked_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .ENT_W      (ENT_W)
   ) u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_data   ({push_key, push_code}),
      .pop         (pop),
      .rd_data_ff  (rd_data),
      .rd_empty_ff (rd_empty),
      .rd_lost_ff  (rd_lost)
   );

   // ---------------------------------------------------------------------
   // Read stage and output register. An empty queue reports zero fields.
   // ---------------------------------------------------------------------
   logic                       ev_valid_ff;
   logic [KEY_W-1:0]           key_ff;
   logic [ked_pkg::CODE_W-1:0] code_ff;
   logic                       lost_ff;

   assign s1_valid_in  = pop || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         ev_valid_ff <= !rd_empty;
         key_ff      <= rd_empty ? '0 : rd_data[ENT_W-1:ked_pkg::CODE_W];
         code_ff     <= rd_empty ? '0 : rd_data[ked_pkg::CODE_W-1:0];
         lost_ff     <= rd_lost;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.event_valid = ev_valid_ff;
   assign rsp_ch.key_index   = key_ff;
   assign rsp_ch.event_code  = code_ff;
   assign rsp_ch.events_lost = lost_ff;

endmodule

// ----- design/ked_lane.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ked_lane - one key: debounce, long press with repeat, double click
// Updates its counters on each scan tick and reports at most one event.
// -----------------------------------------------------------------------------
module ked_lane (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tick,
   input  logic                 down,
   input  ked_pkg::cfg_type     cfg,
   output ked_pkg::lane_ev_type ev
);

   logic [ked_pkg::DEB_W-1:0]    deb_ff, deb_in;
   logic                         pressed_ff, pressed_in;
   logic                         pending_ff, pending_in;
   logic [ked_pkg::WINDOW_W-1:0] win_ff, win_in;
   logic [ked_pkg::LONG_W-1:0]   hold_ff, hold_in;
   logic [ked_pkg::REPEAT_W-1:0] rep_ff, rep_in;

   logic [ked_pkg::DEB_W-1:0]    ft_lo, ft_hi;
   logic [ked_pkg::LONG_W-1:0]   hold_nx;
   logic [ked_pkg::REPEAT_W-1:0] rep_nx;
   logic                         pend_v;
   logic [ked_pkg::WINDOW_W-1:0] win_v;

   assign ft_lo   = {1'b0, cfg.filter_time};
   assign ft_hi   = {cfg.filter_time, 1'b0};
   assign hold_nx = hold_ff + 1'b1;
   assign rep_nx  = rep_ff + 1'b1;

   always_comb begin
      deb_in     = deb_ff;
      pressed_in = pressed_ff;
      pending_in = pending_ff;
      win_in     = win_ff;
      hold_in    = hold_ff;
      rep_in     = rep_ff;
      pend_v     = pending_ff;
      win_v      = win_ff;
      ev         = '{valid: 1'b0, code: ked_pkg::EV_DOWN};
      if (tick) begin
         if (down) begin
            if (deb_ff < ft_lo) begin
               deb_in = ft_lo;
            end else if (deb_ff < ft_hi) begin
               deb_in = deb_ff + 1'b1;
            end else if (!pressed_ff) begin
               pressed_in = 1'b1;
               if (!pending_ff) begin
                  ev = '{valid: 1'b1, code: ked_pkg::EV_DOWN};
               end
            end else if (cfg.long_time != '0) begin
               if (hold_ff < cfg.long_time) begin
                  hold_in = hold_nx;
                  if (hold_nx == cfg.long_time) begin
                     ev = '{valid: 1'b1, code: ked_pkg::EV_LONG};
                  end
               end else if (cfg.repeat_period != '0) begin
                  if (rep_nx >= cfg.repeat_period) begin
                     rep_in = '0;
                     ev     = '{valid: 1'b1, code: ked_pkg::EV_LONG};
                  end else begin
                     rep_in = rep_nx;
                  end
               end
            end
         end else begin
            if (deb_ff > ft_lo) begin
               deb_in = ft_lo;
            end else if (deb_ff != '0) begin
               deb_in = deb_ff - 1'b1;
            end else begin
               // A release inside the window of an earlier click is a double
               // click; otherwise the up event waits for the window to lapse.
               if (pressed_ff) begin
                  pressed_in = 1'b0;
                  pend_v     = 1'b1;
                  if (win_ff < cfg.double_window) begin
                     win_v  = cfg.double_window;
                     pend_v = 1'b0;
                     ev     = '{valid: 1'b1, code: ked_pkg::EV_DOUBLE};
                  end
               end
               if (pend_v) begin
                  if (win_v != '0) begin
                     win_v = win_v - 1'b1;
                  end else begin
                     ev     = '{valid: 1'b1, code: ked_pkg::EV_UP};
                     pend_v = 1'b0;
                     win_v  = cfg.double_window;
                  end
               end
               pending_in = pend_v;
               win_in     = win_v;
            end
            hold_in = '0;
            rep_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ff     <= ked_pkg::DEB_RST;
         pressed_ff <= 1'b0;
         pending_ff <= 1'b0;
         win_ff     <= ked_pkg::WINDOW_RST;
         hold_ff    <= '0;
         rep_ff     <= '0;
      end else begin
         deb_ff     <= deb_in;
         pressed_ff <= pressed_in;
         pending_ff <= pending_in;
         win_ff     <= win_in;
         hold_ff    <= hold_in;
         rep_ff     <= rep_in;
      end
   end

endmodule

// ----- design/ked_merge.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ked_merge - collects the lane events of one tick and serialises them
// Holds the events found on a tick and hands them on one a cycle, lowest key
// first.
// -----------------------------------------------------------------------------
module ked_merge #(
   parameter int NUM_KEYS = 3,
   parameter int KEY_W    = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tick,
   input  ked_pkg::lane_ev_type       lane_ev [NUM_KEYS],
   output logic                       busy,
   output logic                       push_valid,
   output logic [KEY_W-1:0]           push_key,
   output logic [ked_pkg::CODE_W-1:0] push_code
);

   logic [NUM_KEYS-1:0]     pend_ff, pend_in;
   logic [NUM_KEYS-1:0]     grant;
   logic [NUM_KEYS-1:0]     found;
   ked_pkg::ev_code_type    code_ff [NUM_KEYS];

   always_comb begin
      for (int k = 0; k < NUM_KEYS; k++) begin
         found[k] = lane_ev[k].valid;
      end
   end

   assign grant = pend_ff & (~pend_ff + 1'b1);

   always_comb begin
      push_key = '0;
      for (int k = NUM_KEYS - 1; k >= 0; k--) begin
         if (pend_ff[k]) begin
            push_key = KEY_W'(k);
         end
      end
   end

   assign busy       = |pend_ff;
   assign push_valid = busy;
   assign push_code  = code_ff[push_key];
   assign pend_in    = tick ? found : (pend_ff & ~grant);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            code_ff[k] <= lane_ev[k].code;
         end
      end
   end

endmodule

// ----- design/ked_fifo.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ked_fifo - event queue with drop-on-full and a sticky loss flag
// One write port for pushes and one registered read port for pops.
// -----------------------------------------------------------------------------
module ked_fifo #(
   parameter int FIFO_DEPTH = 16,
   parameter int ENT_W      = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [ENT_W-1:0] push_data,
   input  logic             pop,
   output logic [ENT_W-1:0] rd_data_ff,
   output logic             rd_empty_ff,
   output logic             rd_lost_ff
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   logic [ENT_W-1:0] mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             lost_ff, lost_in;
   logic             full, empty, push_ok, pop_ok;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign push_ok = push_valid && !full;
   assign pop_ok  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      lost_in   = lost_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
      if (pop) begin
         lost_in = 1'b0;
      end
      if (push_valid && full) begin
         lost_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         lost_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         lost_ff   <= lost_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (pop) begin
         rd_data_ff  <= mem[rd_ptr_ff];
         rd_empty_ff <= empty;
         rd_lost_ff  <= lost_ff;
      end
   end

endmodule

// ----- design/ked_chk.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ked_chk - port-level checks for the key event detector
// Watches the response channel of the top level; attached by a bind.
// -----------------------------------------------------------------------------
module ked_chk #(
   parameter int NUM_KEYS = 3,
   parameter int KEY_W    = 2
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_event_valid,
   input logic [KEY_W-1:0]           rsp_key_index,
   input logic [ked_pkg::CODE_W-1:0] rsp_event_code,
   input logic                       rsp_events_lost
);

   // An empty-queue response carries zero key and code fields.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_event_valid |-> rsp_key_index == '0 && rsp_event_code == '0)
      else $error("empty response with non-zero fields");

   // A popped event always names an existing key.
   a_key_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_valid |-> rsp_key_index <= KEY_W'(NUM_KEYS - 1))
      else $error("response names a key that does not exist");

   // Reset leaves no response pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // A stalled response stays offered with the same payload.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_valid)
         && $stable(rsp_key_index) && $stable(rsp_event_code)
         && $stable(rsp_events_lost))
      else $error("stalled response changed or was withdrawn");

endmodule

bind key_event_detector_core ked_chk #(
   .NUM_KEYS (NUM_KEYS),
   .KEY_W    (KEY_W)
) u_ked_chk (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_event_valid (rsp_ch.event_valid),
   .rsp_key_index   (rsp_ch.key_index),
   .rsp_event_code  (rsp_ch.event_code),
   .rsp_events_lost (rsp_ch.events_lost)
);

// ----- sim/key_event_model_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// key_event_model_pkg - event prediction and scoreboard for the key detector
// Keeps its own copy of the registers, the per-key counters and the event
// queue, predicts the outcome of every read transaction and checks responses.
// -----------------------------------------------------------------------------
package key_event_model_pkg;
   import ked_pkg::*;

   localparam int KEYS  = 3;
   localparam int DEPTH = 16;

   typedef struct packed {
      logic        ev_valid;
      logic [1:0]  key_index;
      ev_code_type code;
      logic        lost;
   } read_outcome_type;

   class key_event_scoreboard;
      logic [FILTER_W-1:0] filter_time;
      logic [LONG_W-1:0]   long_time;
      logic [REPEAT_W-1:0] repeat_period;
      logic [WINDOW_W-1:0] double_window;

      logic [DEB_W-1:0]    deb_cnt    [KEYS];
      bit                  pressed    [KEYS];
      bit                  click_open [KEYS];
      logic [WINDOW_W-1:0] window_cnt [KEYS];
      logic [LONG_W-1:0]   hold_cnt   [KEYS];
      logic [REPEAT_W-1:0] repeat_cnt [KEYS];

      logic [3:0]          store [DEPTH];
      int                  rd_ptr;
      int                  wr_ptr;
      int                  fill;
      bit                  lost;

      read_outcome_type    expected_reads [$];

      int n_errors;
      int n_ticks;
      int n_reads;
      int n_empty;
      int n_dropped;
      int n_code [4];

      function new();
         filter_time   = FILTER_RST;
         long_time     = LONG_RST;
         repeat_period = REPEAT_RST;
         double_window = WINDOW_RST;
         for (int k = 0; k < KEYS; k++) begin
            deb_cnt[k]    = DEB_RST;
            pressed[k]    = 1'b0;
            click_open[k] = 1'b0;
            window_cnt[k] = WINDOW_RST;
            hold_cnt[k]   = '0;
            repeat_cnt[k] = '0;
         end
         foreach (store[i]) store[i] = '0;
         rd_ptr = 0;
         wr_ptr = 0;
         fill   = 0;
         lost   = 1'b0;
      endfunction

      function void write_reg(reg_idx_type idx, logic [31:0] value);
         case (idx)
            REG_FILTER: filter_time   = value[FILTER_W-1:0];
            REG_LONG:   long_time     = value[LONG_W-1:0];
            REG_REPEAT: repeat_period = value[REPEAT_W-1:0];
            REG_WINDOW: double_window = value[WINDOW_W-1:0];
            default: ;
         endcase
      endfunction

      // A full queue drops the new event and remembers that it did.
      function void queue_event(int k, ev_code_type code);
         if (fill >= DEPTH) begin
            lost = 1'b1;
            n_dropped++;
            return;
         end
         store[wr_ptr] = {k[1:0], code};
         wr_ptr = (wr_ptr + 1) % DEPTH;
         fill++;
         n_code[code]++;
      endfunction

      function void scan_key(int k, bit down);
         int ft;
         ft = filter_time;
         if (down) begin
            if (deb_cnt[k] < ft) begin
               deb_cnt[k] = DEB_W'(ft);
            end else if (deb_cnt[k] < 2 * ft) begin
               deb_cnt[k] = deb_cnt[k] + 1'b1;
            end else begin
               if (!pressed[k]) begin
                  pressed[k] = 1'b1;
                  // The second press of a double click raises no down event.
                  if (!click_open[k]) queue_event(k, EV_DOWN);
                  return;
               end
               if (long_time != 0) begin
                  if (hold_cnt[k] < long_time) begin
                     hold_cnt[k] = hold_cnt[k] + 1'b1;
                     if (hold_cnt[k] == long_time) queue_event(k, EV_LONG);
                  end else if (repeat_period != 0) begin
                     repeat_cnt[k] = repeat_cnt[k] + 1'b1;
                     if (repeat_cnt[k] >= repeat_period) begin
                        repeat_cnt[k] = '0;
                        queue_event(k, EV_LONG);
                     end
                  end
               end
            end
         end else begin
            if (deb_cnt[k] > ft) begin
               deb_cnt[k] = DEB_W'(ft);
            end else if (deb_cnt[k] != 0) begin
               deb_cnt[k] = deb_cnt[k] - 1'b1;
            end else begin
               if (pressed[k]) begin
                  pressed[k]    = 1'b0;
                  click_open[k] = 1'b1;
                  if (window_cnt[k] < double_window) begin
                     window_cnt[k] = double_window;
                     click_open[k] = 1'b0;
                     queue_event(k, EV_DOUBLE);
                  end
               end
               if (click_open[k]) begin
                  if (window_cnt[k] != 0) begin
                     window_cnt[k] = window_cnt[k] - 1'b1;
                  end else begin
                     queue_event(k, EV_UP);
                     click_open[k] = 1'b0;
                     window_cnt[k] = double_window;
                  end
               end
            end
            hold_cnt[k]   = '0;
            repeat_cnt[k] = '0;
         end
      endfunction

      function void note_input(logic kind, logic [KEYS-1:0] levels);
         read_outcome_type r;
         if (kind == KIND_TICK) begin
            n_ticks++;
            for (int k = 0; k < KEYS; k++) scan_key(k, levels[k]);
         end else begin
            n_reads++;
            r.lost = lost;
            lost   = 1'b0;
            if (fill == 0) begin
               r.ev_valid  = 1'b0;
               r.key_index = '0;
               r.code      = EV_DOWN;
               n_empty++;
            end else begin
               r.ev_valid  = 1'b1;
               r.key_index = store[rd_ptr][3:2];
               r.code      = ev_code_type'(store[rd_ptr][1:0]);
               rd_ptr      = (rd_ptr + 1) % DEPTH;
               fill--;
            end
            expected_reads.push_back(r);
         end
      endfunction

      function void check_result(logic ev_valid, logic [1:0] key_index,
                                 logic [1:0] code, logic lost_flag);
         read_outcome_type want;
         if (expected_reads.size() == 0) begin
            $error("response transaction with no read outstanding");
            n_errors++;
            return;
         end
         want = expected_reads.pop_front();
         if (ev_valid !== want.ev_valid) begin
            $error("event_valid: expected %0d, actual %0d", want.ev_valid, ev_valid);
            n_errors++;
         end
         if (key_index !== want.key_index) begin
            $error("key_index: expected %0d, actual %0d", want.key_index, key_index);
            n_errors++;
         end
         if (code !== want.code) begin
            $error("event_code: expected %0d, actual %0d", want.code, code);
            n_errors++;
         end
         if (lost_flag !== want.lost) begin
            $error("events_lost: expected %0d, actual %0d", want.lost, lost_flag);
            n_errors++;
         end
      endfunction

      function int pending();
         return expected_reads.size();
      endfunction
   endclass

endpackage

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top - self-checking bench for the key event detector core
// Drives scan ticks and read transactions through several register settings,
// with random idling on both channels and one long response stall, and checks
// every read response against the scoreboard's prediction.
// -----------------------------------------------------------------------------
module tb_top;
   import ked_pkg::*;
   import key_event_model_pkg::*;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int PRESSURE_CYCLES = 300;
   // A tick keeps the block busy with nothing to show for it while the merging
   // stage writes its events; drain_block settles for SETTLE_CYCLES first.
   localparam int SETTLE_CYCLES   = 8;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [APB_ADDR_W-1:0] paddr;
   logic [APB_DATA_W-1:0] pwdata;
   logic [APB_DATA_W-1:0] prdata;
   logic                  pready;

   ked_req_if #(.NUM_KEYS(KEYS)) req_if ();
   ked_rsp_if #(.KEY_W(2))       rsp_if ();

   key_event_detector_core #(
      .NUM_KEYS   (KEYS),
      .FIFO_DEPTH (DEPTH)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   key_event_scoreboard events_sb;

   // Idling rates in percent for the sender and the receiver.
   int src_idle_pct;
   int snk_idle_pct;

   // The stimulus asks for a long response stall through this flag; the
   // receiver process then counts the stall down on its own.
   bit hold_req;
   int hold_left;

   // Per-key level that the random traffic holds, and how long it holds it.
   bit held     [KEYS];
   int run_left [KEYS];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: ready changes on the falling edge only.
   initial begin
      rsp_if.ready = 1'b0;
      hold_left    = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = PRESSURE_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
         end
      end
   end

   // Everything that moves is observed on the rising edge. Register writes
   // and accepted requests go to the scoreboard before responses are checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (psel && penable && pwrite && pready)
            events_sb.write_reg(reg_idx_type'(paddr[3:2]), pwdata);
         if (req_if.valid && req_if.ready)
            events_sb.note_input(req_if.kind, req_if.key_levels);
         if (rsp_if.valid && rsp_if.ready)
            events_sb.check_result(rsp_if.event_valid, rsp_if.key_index,
                                   rsp_if.event_code, rsp_if.events_lost);
      end
   end

   // The watchdog ends the run if no transaction of any kind moves for too
   // long; the longest deliberate gap is the receiver's long stall.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      wait (reset === 1'b0);
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (psel && penable && pwrite && pready))
            quiet = 0;
         else
            quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Offers one request transaction and returns on the falling edge after it
   // has been accepted. Idle cycles are inserted in front of it at random.
   task automatic send_item(input logic kind, input logic [KEYS-1:0] levels);
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.kind       <= kind;
      req_if.key_levels <= levels;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      @(negedge clock);
   endtask

   // One register write: a setup phase, then an access phase that completes
   // when pready is seen, then a pause with psel low.
   task automatic write_csr(input reg_idx_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // Registers are only touched once every read has been answered and any
   // tick still in the merging stage has had time to finish.
   task automatic drain_block();
      req_if.valid <= 1'b0;
      while (events_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_registers(input int ft, input int lt, input int rp, input int dw);
      drain_block();
      write_csr(REG_FILTER, ft);
      write_csr(REG_LONG,   lt);
      write_csr(REG_REPEAT, rp);
      write_csr(REG_WINDOW, dw);
   endtask

   // Random traffic built from key presses and releases of random length,
   // with some contact bounce mixed in, interleaved with reads.
   task automatic run_traffic(input int n_items, input int read_pct,
                              input int run_lo, input int run_hi, input int bounce_pct);
      logic [KEYS-1:0] levels;
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < read_pct) begin
            send_item(KIND_READ, KEYS'($urandom));
         end else begin
            for (int k = 0; k < KEYS; k++) begin
               if (run_left[k] == 0) begin
                  held[k]     = !held[k];
                  run_left[k] = $urandom_range(run_hi, run_lo);
               end
               run_left[k]--;
               levels[k] = held[k] ^ ($urandom_range(99) < bounce_pct);
            end
            send_item(KIND_TICK, levels);
         end
      end
   endtask

   initial begin
      events_sb         = new();
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_if.valid      = 1'b0;
      req_if.kind       = KIND_TICK;
      req_if.key_levels = '0;
      src_idle_pct      = 0;
      snk_idle_pct      = 0;
      hold_req          = 1'b0;
      for (int k = 0; k < KEYS; k++) begin
         held[k]     = 1'b0;
         run_left[k] = 1;
      end
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed part. A zero filter takes every press on the first tick and
      // the short long and repeat times pile events up quickly: the queue is
      // read while empty, then overfilled so that events are dropped, and the
      // next read must report the loss exactly once.
      set_registers(0, 2, 1, 3);
      send_item(KIND_READ, '0);
      repeat (7) send_item(KIND_TICK, 3'b111);
      repeat (3) send_item(KIND_READ, '1);
      repeat (2) send_item(KIND_TICK, 3'b000);
      send_item(KIND_TICK, 3'b101);
      send_item(KIND_TICK, 3'b010);
      repeat (4) send_item(KIND_TICK, 3'b000);
      repeat (5) send_item(KIND_READ, '0);

      // Sender idles rarely, receiver often.
      src_idle_pct = 17;
      snk_idle_pct = 73;
      set_registers(1, 3, 1, 4);
      run_traffic(200, 30, 1, 12, 3);
      // Few reads here, so the queue overflows now and then.
      set_registers(2, 6, 3, 6);
      run_traffic(200, 5, 1, 20, 5);

      // The other way round, starting at the top of every register.
      src_idle_pct = 73;
      snk_idle_pct = 17;
      set_registers(31, 65535, 65535, 255);
      run_traffic(150, 20, 40, 120, 2);
      set_registers(1, 0, 0, 0);
      run_traffic(150, 60, 1, 8, 5);

      // No idling from here on. The receiver first stalls for a long stretch
      // while requests keep coming, so the block fills up and holds its input.
      src_idle_pct = 0;
      snk_idle_pct = 0;
      set_registers(3, 5, 0, 255);
      @(posedge clock);
      hold_req = 1'b1;
      @(negedge clock);
      run_traffic(150, 30, 2, 25, 3);
      set_registers(0, 2, 2, 1);
      run_traffic(150, 30, 1, 6, 0);
      set_registers(5, 100, 100, 30);
      run_traffic(200, 25, 5, 150, 2);

      drain_block();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d scan ticks and %0d read transactions, %0d of them on an empty queue.",
               events_sb.n_ticks, events_sb.n_reads, events_sb.n_empty);
      $display("Events queued: %0d down, %0d up, %0d long, %0d double click; %0d dropped.",
               events_sb.n_code[EV_DOWN], events_sb.n_code[EV_UP],
               events_sb.n_code[EV_LONG], events_sb.n_code[EV_DOUBLE], events_sb.n_dropped);
      if (events_sb.n_errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
